### rtl/core/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// shared constants, types and codes of the bitmap frame allocator
// ----------------------------------------------------------------------------
package bfa_pkg;

	// geometry; the word width is a power of two
	localparam int FRAMES     = 8192;
	localparam int PAGE_SHIFT = 12;
	localparam int WORD_BITS  = 32;

	localparam int NWORDS  = (FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int BIT_W   = $clog2(WORD_BITS);
	localparam int POP_W   = BIT_W + 1;
	localparam int FRAME_W = $clog2(FRAMES + 1);
	localparam int TOPB_W  = FRAME_W + PAGE_SHIFT;

	// field widths of the transactions
	localparam int ADDR_OUT_W  = 25;
	localparam int COUNT_OUT_W = 14;

	localparam logic [63:0] TOP_BYTES = 64'(FRAMES) << PAGE_SHIFT;

	typedef enum logic [1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_FREE    = 2'd1,
		KIND_RESERVE = 2'd2,
		KIND_ADD     = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		kind_t        kind;
		logic [31:0]  free_address;
		logic [63:0]  range_base;
		logic [63:0]  range_length;
		logic         region_usable;
	} bfa_in_t;

	typedef struct packed {
		logic [ADDR_OUT_W-1:0]  frame_address;
		logic                   out_of_memory;
		logic [COUNT_OUT_W-1:0] free_count;
		logic [COUNT_OUT_W-1:0] total_count;
	} bfa_out_t;

	// word span of one request, from the range preparation to the walker
	typedef struct packed {
		logic              valid;
		logic              empty;
		logic [WIDX_W-1:0] first_w;
		logic [WIDX_W-1:0] end_w;
		logic [BIT_W-1:0]  lo_bit;
		logic [POP_W-1:0]  hi_cnt;
	} bfa_span_t;

endpackage

### rtl/core/bitmap_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// first-fit page frame allocator over a one-bit-per-frame bitmap in memory
// ----------------------------------------------------------------------------
// usage
//   a request transaction is taken when start is high and busy is low; the
//   request struct carries kind, free_address, range_base, range_length and
//   region_usable. kinds: alloc, free frame, reserve range, add usable range
//   exactly one result transaction per request: done is high for one cycle
//   with the result struct valid; the receiver cannot stall it
//   busy is high from the accept through the done cycle, so one request
//   is in work at a time
// operation
//   a request walks bitmap words through a read-modify-write pipeline, one
//   word a cycle over the memory's read port: a single word for free, up to
//   256 words for wide ranges, and alloc stops at the word holding the first
//   free frame; done follows once the pipeline has drained, and the next
//   request can be taken after done; an empty or out-of-range request goes
//   from the range preparation to done without reading the bitmap
// reset
//   arst_n clears the counters and the word-written marks of the memory, so
//   the whole bitmap reads as used at once; no clearing pass is needed
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bfa_pkg::bfa_in_t  request,
	output logic              done,
	output bfa_pkg::bfa_out_t result
);
	import bfa_pkg::*;

	state_t state_q;
	state_t state_d;

	kind_t              kind_q;
	logic [WIDX_W-1:0]  widx_q;
	logic               found_q;
	logic [ADDR_OUT_W-1:0] addr_q;
	logic [FRAME_W-1:0] free_q;
	logic [FRAME_W-1:0] total_q;

	// read-modify-write pipeline
	logic               vld_s1;
	logic [WIDX_W-1:0]  idx_s1;
	logic               vld_s2;
	logic [POP_W-1:0]   cnt_s2;

	logic               accept;
	logic               issue;
	bfa_span_t          span;

	logic [WORD_BITS-1:0] rd_data;
	logic [WORD_BITS-1:0] wr_data;
	logic                 wr_en;

	assign accept = start && !busy;

	// range preparation: request -> word span
	bfa_range_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (accept),
		.request (request),
		.span    (span)
	);

	// bitmap storage
	bfa_bitmap_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (issue),
		.rd_addr (widx_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (idx_s1),
		.wr_data (wr_data)
	);

	// stage 1: modify the word that came back from memory
	logic                 act_s1;
	logic                 hit_s1;
	logic [WORD_BITS-1:0] lo_m;
	logic [WORD_BITS-1:0] hi_m;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] inv;
	logic [WORD_BITS-1:0] low1;
	logic [BIT_W-1:0]     bit_idx;
	logic [WORD_BITS-1:0] changed;

	always_comb begin
		act_s1 = vld_s1 && !found_q;
		lo_m   = '1 << ((idx_s1 == span.first_w) ? span.lo_bit : '0);
		hi_m   = (idx_s1 == span.end_w) ? ~('1 << span.hi_cnt) : '1;
		mask   = lo_m & hi_m;
		// lowest free frame of the word
		inv    = ~rd_data;
		low1   = inv & (~inv + WORD_BITS'(1));
		bit_idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (low1[i]) begin
				bit_idx = bit_idx | BIT_W'(i);
			end
		end
		hit_s1 = 1'b0;
		case (kind_q)
			KIND_ALLOC: begin
				hit_s1  = act_s1 && (rd_data != '1);
				wr_data = rd_data | low1;
				wr_en   = hit_s1;
			end
			KIND_RESERVE: begin
				wr_data = rd_data | mask;
				wr_en   = act_s1;
			end
			default: begin
				wr_data = rd_data & ~mask;
				wr_en   = act_s1;
			end
		endcase
		changed = rd_data ^ wr_data;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (span.valid) begin
					state_d = span.empty ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if ((widx_q == span.end_w) || found_q || hit_s1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!vld_s1 && !vld_s2) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the state machine
	always_comb begin
		busy  = 1'b1;
		done  = 1'b0;
		issue = 1'b0;
		case (state_q)
			ST_IDLE: busy  = 1'b0;
			ST_SCAN: issue = !found_q && !hit_s1;
			ST_DONE: done  = 1'b1;
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			vld_s2  <= act_s1;
			if (accept) begin
				found_q <= 1'b0;
			end else if (hit_s1) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= request.kind;
		end
		if ((state_q == ST_PREP) && span.valid) begin
			widx_q <= span.first_w;
		end else if (issue) begin
			widx_q <= widx_q + WIDX_W'(1);
		end
		idx_s1 <= widx_q;
		cnt_s2 <= POP_W'($countones(changed));
		if (hit_s1) begin
			addr_q <= ADDR_OUT_W'({idx_s1, bit_idx}) << PAGE_SHIFT;
		end
	end

	// stage 2: counters; free saturates at zero and at the top, total at the top
	logic [FRAME_W:0] free_sum;
	logic [FRAME_W:0] total_sum;

	always_comb begin
		free_sum  = {1'b0, free_q} + (FRAME_W + 1)'(cnt_s2);
		total_sum = {1'b0, total_q} + (FRAME_W + 1)'(cnt_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q  <= '0;
			total_q <= '0;
		end else if (vld_s2) begin
			case (kind_q)
				KIND_ALLOC, KIND_RESERVE: begin
					free_q <= (free_q > FRAME_W'(cnt_s2)) ? free_q - FRAME_W'(cnt_s2) : '0;
				end
				KIND_FREE: begin
					free_q <= (free_sum > (FRAME_W + 1)'(FRAMES)) ?
						FRAME_W'(FRAMES) : free_sum[FRAME_W-1:0];
				end
				default: begin
					free_q  <= (free_sum > (FRAME_W + 1)'(FRAMES)) ?
						FRAME_W'(FRAMES) : free_sum[FRAME_W-1:0];
					total_q <= (total_sum > (FRAME_W + 1)'(FRAMES)) ?
						FRAME_W'(FRAMES) : total_sum[FRAME_W-1:0];
				end
			endcase
		end
	end

	// result transaction
	always_comb begin
		result.frame_address = ((kind_q == KIND_ALLOC) && found_q) ? addr_q : '0;
		result.out_of_memory = (kind_q == KIND_ALLOC) && !found_q;
		result.free_count    = COUNT_OUT_W'(free_q);
		result.total_count   = COUNT_OUT_W'(total_q);
	end

	// checks
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for more than one cycle");

	a_write_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> vld_s1) else $error("bitmap write without a word in stage 1");

	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_PREP) && busy) else $error("accept did not start a request");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q <= FRAME_W'(FRAMES)) && (total_q <= FRAME_W'(FRAMES)))
		else $error("frame count above limit");

	a_oom_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.out_of_memory) |-> (free_q == '0))
		else $error("out of memory while free frames are counted");

endmodule

### rtl/core/bfa_bitmap_mem.sv
// ----------------------------------------------------------------------------
// bfa_bitmap_mem
// frame bitmap storage, one write and one read port, registered read data;
// words never written read as all ones (every frame used)
// ----------------------------------------------------------------------------
module bfa_bitmap_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [bfa_pkg::WIDX_W-1:0]    rd_addr,
	output logic [bfa_pkg::WORD_BITS-1:0] rd_data,
	input  logic                          wr_en,
	input  logic [bfa_pkg::WIDX_W-1:0]    wr_addr,
	input  logic [bfa_pkg::WORD_BITS-1:0] wr_data
);
	import bfa_pkg::*;

	logic [WORD_BITS-1:0] bitmap_mem [NWORDS];
	logic [NWORDS-1:0]    wvld_q;
	logic [WORD_BITS-1:0] rd_raw_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bitmap_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= bitmap_mem[rd_addr];
		end
	end

	// per-word written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvld_q   <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				wvld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= wvld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : '1;

endmodule

### rtl/core/bfa_range_prep.sv
// ----------------------------------------------------------------------------
// bfa_range_prep
// turns a request into a span of bitmap words: clipped region end first,
// then page rounding and word/bit split
// ----------------------------------------------------------------------------
module bfa_range_prep (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  bfa_pkg::bfa_in_t   request,
	output bfa_pkg::bfa_span_t span
);
	import bfa_pkg::*;

	// stage 1
	logic              v_s1;
	kind_t             kind_s1;
	logic              inr_s1;
	logic [TOPB_W-1:0] base_s1;
	logic [TOPB_W-1:0] end_s1;
	logic [FRAME_W-1:0] fidx_s1;

	logic [64:0]       sum_c;
	logic [TOPB_W-1:0] end_c;
	logic              base_in_c;
	logic [31:0]       fpage_c;
	logic              free_in_c;
	logic              inr_c;

	always_comb begin
		sum_c     = {1'b0, request.range_base} + {1'b0, request.range_length};
		base_in_c = request.range_base < TOP_BYTES;
		// saturate then clip at top of memory
		if (sum_c[64] || (sum_c[63:0] > TOP_BYTES)) begin
			end_c = TOP_BYTES[TOPB_W-1:0];
		end else begin
			end_c = sum_c[TOPB_W-1:0];
		end
		fpage_c   = request.free_address >> PAGE_SHIFT;
		free_in_c = fpage_c < 32'(FRAMES);
		case (request.kind)
			KIND_ALLOC:   inr_c = 1'b1;
			KIND_FREE:    inr_c = free_in_c;
			KIND_RESERVE: inr_c = base_in_c;
			KIND_ADD:     inr_c = base_in_c && request.region_usable;
			default:      inr_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			kind_s1 <= request.kind;
			inr_s1  <= inr_c;
			base_s1 <= request.range_base[TOPB_W-1:0];
			end_s1  <= end_c;
			fidx_s1 <= fpage_c[FRAME_W-1:0];
		end
	end

	// stage 2
	logic [FRAME_W-1:0] first_c;
	logic [FRAME_W-1:0] last_c;
	logic [FRAME_W-1:0] lastm1_c;
	logic [FRAME_W-1:0] fw_c;
	logic [FRAME_W-1:0] ew_c;
	logic [FRAME_W-1:0] base_pg_c;
	logic [FRAME_W-1:0] end_pg_c;
	logic               base_off_c;
	logic               end_off_c;

	always_comb begin
		base_pg_c  = FRAME_W'(base_s1 >> PAGE_SHIFT);
		end_pg_c   = FRAME_W'(end_s1 >> PAGE_SHIFT);
		base_off_c = |base_s1[PAGE_SHIFT-1:0];
		end_off_c  = |end_s1[PAGE_SHIFT-1:0];
		case (kind_s1)
			KIND_ALLOC: begin
				first_c = '0;
				last_c  = FRAME_W'(FRAMES);
			end
			KIND_FREE: begin
				first_c = fidx_s1;
				last_c  = fidx_s1 + FRAME_W'(1);
			end
			KIND_RESERVE: begin
				first_c = base_pg_c;
				last_c  = end_pg_c + FRAME_W'(end_off_c);
			end
			default: begin
				first_c = base_pg_c + FRAME_W'(base_off_c);
				last_c  = end_pg_c;
			end
		endcase
		lastm1_c = last_c - FRAME_W'(1);
		fw_c     = first_c >> BIT_W;
		ew_c     = lastm1_c >> BIT_W;
	end

	logic              vld_s2;
	logic              empty_s2;
	logic [WIDX_W-1:0] first_w_s2;
	logic [WIDX_W-1:0] end_w_s2;
	logic [BIT_W-1:0]  lo_bit_s2;
	logic [POP_W-1:0]  hi_cnt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			empty_s2   <= !inr_s1 || (last_c <= first_c);
			first_w_s2 <= fw_c[WIDX_W-1:0];
			end_w_s2   <= ew_c[WIDX_W-1:0];
			lo_bit_s2  <= first_c[BIT_W-1:0];
			hi_cnt_s2  <= {1'b0, lastm1_c[BIT_W-1:0]} + POP_W'(1);
		end
	end

	always_comb begin
		span.valid   = vld_s2;
		span.empty   = empty_s2;
		span.first_w = first_w_s2;
		span.end_w   = end_w_s2;
		span.lo_bit  = lo_bit_s2;
		span.hi_cnt  = hi_cnt_s2;
	end

endmodule
